// ===== hw/rtl/bxpc_pkg.sv =====
// Shared types, constants and the popcount function for the XNOR-popcount MAC.
// No dependencies; every other file in hw/rtl refers to it by scoped names.
package bxpc_pkg;

	localparam int unsigned WordW    = 32;
	localparam int unsigned CntW     = 6;
	localparam int unsigned TotalW   = 17;
	localparam int unsigned SumW     = 16;
	localparam int unsigned ScaleW   = 16;
	localparam int unsigned RawW     = 18;
	localparam int unsigned Prod1W   = RawW + ScaleW + 1;
	localparam int unsigned Prod2W   = Prod1W + ScaleW + 1;
	localparam int unsigned ScaledW  = 48;

	localparam logic [TotalW-1:0]         TotalMax  = '1;
	localparam logic signed [RawW-1:0]    RawMax    = 18'sh1FFFF;
	localparam logic signed [ScaledW-1:0] ScaledMax = {1'b0, {(ScaledW-1){1'b1}}};
	localparam logic signed [ScaledW-1:0] ScaledMin = {1'b1, {(ScaledW-1){1'b0}}};

	// ones count of each nibble value
	localparam logic [2:0] NibbleOnes [16] = '{
		3'd0, 3'd1, 3'd1, 3'd2, 3'd1, 3'd2, 3'd2, 3'd3,
		3'd1, 3'd2, 3'd2, 3'd3, 3'd2, 3'd3, 3'd3, 3'd4
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RAW,
		ST_MUL1,
		ST_MUL2,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic acc_en;
		logic cap_en;
		logic raw_en;
		logic mul1_en;
		logic mul2_en;
		logic out_load;
	} cmd_t;

	// count set bits through the nibble table
	function automatic logic [CntW-1:0] count_ones(input logic [WordW-1:0] w);
		logic [CntW-1:0] n;
		n = '0;
		for (int i = 0; i < WordW / 4; i++) begin
			n = n + CntW'(NibbleOnes[w[4*i +: 4]]);
		end
		return n;
	endfunction

endpackage

// ===== hw/rtl/bxpc_ctrl.sv =====
// Controller of the XNOR-popcount MAC: sequences the scale multiplies
// and owns the input and output handshakes. Depends on bxpc_pkg.
module bxpc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          last,
	output logic          out_valid,
	input  logic          out_stall,
	output bxpc_pkg::cmd_t cmd
);

	bxpc_pkg::state_t state_q, state_d;
	logic out_valid_q;
	logic in_acc;

	assign in_stall  = (state_q != bxpc_pkg::ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bxpc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// next state and commands
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.acc_en   = in_acc;
		cmd.cap_en   = in_acc && last;
		unique case (state_q)
			bxpc_pkg::ST_IDLE: begin
				if (in_acc && last) begin
					state_d = bxpc_pkg::ST_RAW;
				end
			end
			bxpc_pkg::ST_RAW: begin
				cmd.raw_en = 1'b1;
				state_d    = bxpc_pkg::ST_MUL1;
			end
			bxpc_pkg::ST_MUL1: begin
				cmd.mul1_en = 1'b1;
				state_d     = bxpc_pkg::ST_MUL2;
			end
			bxpc_pkg::ST_MUL2: begin
				cmd.mul2_en = 1'b1;
				state_d     = bxpc_pkg::ST_DONE;
			end
			bxpc_pkg::ST_DONE: begin
				// load the output register once it is free or being drained
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = bxpc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bxpc_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/bxpc_dp.sv =====
// Datapath of the XNOR-popcount MAC: popcount accumulator, raw sum,
// two scale multiplies and the saturating output register. Depends on bxpc_pkg.
module bxpc_dp #(
	parameter int unsigned WORD_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bxpc_pkg::cmd_t                      cmd,
	input  logic [bxpc_pkg::WordW-1:0]          act_word,
	input  logic [bxpc_pkg::WordW-1:0]          weight_word,
	input  logic [bxpc_pkg::SumW-1:0]           valid_bits,
	input  logic [bxpc_pkg::ScaleW-1:0]         channel_scale,
	input  logic [bxpc_pkg::ScaleW-1:0]         position_scale,
	output logic signed [bxpc_pkg::RawW-1:0]    raw_sum,
	output logic signed [bxpc_pkg::ScaledW-1:0] scaled_value
);

	localparam logic [bxpc_pkg::WordW-1:0] WordMask =
		bxpc_pkg::WordW'((64'd1 << WORD_BITS) - 64'd1);

	logic [bxpc_pkg::TotalW-1:0]          total_q;
	logic [bxpc_pkg::SumW-1:0]            vb_q;
	logic [bxpc_pkg::ScaleW-1:0]          cs_q;
	logic [bxpc_pkg::ScaleW-1:0]          ps_q;
	logic signed [bxpc_pkg::RawW-1:0]     raw_s1;
	logic signed [bxpc_pkg::Prod1W-1:0]   prod_s2;
	logic signed [bxpc_pkg::Prod2W-1:0]   prod_s3;
	logic signed [bxpc_pkg::RawW-1:0]     raw_sum_q;
	logic signed [bxpc_pkg::ScaledW-1:0]  scaled_q;

	logic [bxpc_pkg::WordW-1:0]           xnor_w;
	logic [bxpc_pkg::CntW-1:0]            cnt;
	logic [bxpc_pkg::TotalW:0]            acc_sum;
	logic [bxpc_pkg::TotalW-1:0]          total_d;
	logic signed [bxpc_pkg::RawW:0]       raw_full;
	logic signed [bxpc_pkg::RawW-1:0]     raw_d;
	logic signed [bxpc_pkg::ScaledW-1:0]  scaled_d;

	// count matching bits within the word
	assign xnor_w  = ~(act_word ^ weight_word) & WordMask;
	assign cnt     = bxpc_pkg::count_ones(xnor_w);
	assign acc_sum = {1'b0, total_q} + (bxpc_pkg::TotalW + 1)'(cnt);
	assign total_d = acc_sum[bxpc_pkg::TotalW] ? bxpc_pkg::TotalMax
	                                           : acc_sum[bxpc_pkg::TotalW-1:0];

	// raw = 2 * matches - valid bits, clamped at the top
	assign raw_full = $signed({1'b0, total_q, 1'b0}) -
	                  $signed({3'b000, vb_q});
	assign raw_d = (raw_full > (bxpc_pkg::RawW + 1)'(bxpc_pkg::RawMax))
	               ? bxpc_pkg::RawMax : raw_full[bxpc_pkg::RawW-1:0];

	// clamp the full product to the output range
	always_comb begin
		if (prod_s3 > (bxpc_pkg::Prod2W)'(bxpc_pkg::ScaledMax)) begin
			scaled_d = bxpc_pkg::ScaledMax;
		end else if (prod_s3 < (bxpc_pkg::Prod2W)'(bxpc_pkg::ScaledMin)) begin
			scaled_d = bxpc_pkg::ScaledMin;
		end else begin
			scaled_d = prod_s3[bxpc_pkg::ScaledW-1:0];
		end
	end

	// accumulate matches, clear after the raw sum is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (cmd.raw_en) begin
			total_q <= '0;
		end else if (cmd.acc_en) begin
			total_q <= total_d;
		end
	end

	// advance operands through the multiply stages
	always_ff @(posedge clk) begin
		if (cmd.cap_en) begin
			vb_q <= valid_bits;
			cs_q <= channel_scale;
			ps_q <= position_scale;
		end
		if (cmd.raw_en) begin
			raw_s1 <= raw_d;
		end
		if (cmd.mul1_en) begin
			prod_s2 <= (bxpc_pkg::Prod1W)'(raw_s1) * $signed({1'b0, cs_q});
		end
		if (cmd.mul2_en) begin
			prod_s3 <= (bxpc_pkg::Prod2W)'(prod_s2) * $signed({1'b0, ps_q});
		end
		if (cmd.out_load) begin
			raw_sum_q <= raw_s1;
			scaled_q  <= scaled_d;
		end
	end

	assign raw_sum      = raw_sum_q;
	assign scaled_value = scaled_q;

endmodule

// ===== hw/rtl/binary_xnor_popcount_conv_mac.sv =====
// Top level of the binary-network XNOR-popcount convolution MAC.
// Instantiates bxpc_ctrl and bxpc_dp; uses bxpc_pkg.
//
// Each transaction on the input brings one activation word and one weight word; the
// block XNORs their low WORD_BITS bits, counts the matches and adds them to a total that
// saturates at 131071. An item without last gives no result. An
// item with last also forms raw_sum = 2*matches - valid_bits (clamped at 131071),
// multiplies it by channel_scale and position_scale (Q4.12 each) and presents the
// Q24.24 result saturated to 48 bits; the input stalls after it while the raw sum and the
// two registered multiplies run, then the result is loaded into the output register and
// the input opens again. A result waiting on out_stall does not block new input items;
// only the next last item waits for the output register to drain.
module binary_xnor_popcount_conv_mac #(
	parameter int unsigned WORD_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [bxpc_pkg::WordW-1:0]          act_word,
	input  logic [bxpc_pkg::WordW-1:0]          weight_word,
	input  logic                                last,
	input  logic [bxpc_pkg::SumW-1:0]           valid_bits,
	input  logic [bxpc_pkg::ScaleW-1:0]         channel_scale,
	input  logic [bxpc_pkg::ScaleW-1:0]         position_scale,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [bxpc_pkg::RawW-1:0]    raw_sum,
	output logic signed [bxpc_pkg::ScaledW-1:0] scaled_value
);

	bxpc_pkg::cmd_t cmd;

	bxpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.last      (last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	bxpc_dp #(
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.act_word       (act_word),
		.weight_word    (weight_word),
		.valid_bits     (valid_bits),
		.channel_scale  (channel_scale),
		.position_scale (position_scale),
		.raw_sum        (raw_sum),
		.scaled_value   (scaled_value)
	);

endmodule

// ===== hw/rtl/bxpc_checker.sv =====
// Port-level checks for the XNOR-popcount MAC, bound to the top level.
// Depends on bxpc_pkg and binary_xnor_popcount_conv_mac.
module bxpc_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                last,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic signed [bxpc_pkg::RawW-1:0]    raw_sum,
	input logic signed [bxpc_pkg::ScaledW-1:0] scaled_value
);

	logic in_acc;
	assign in_acc = in_valid && !in_stall;

	// a last transaction closes the input while the multiplies run
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && last |=> in_stall)
		else $error("input open right after a last transaction");

	// a plain transaction leaves the input open
	a_plain_open: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !last |=> !in_stall)
		else $error("input closed after a non-last transaction");

	// a fresh result follows a last transaction by a fixed latency
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_acc && last, 5))
		else $error("result without matching last transaction");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(raw_sum) && $stable(scaled_value))
		else $error("stalled result changed");

	// raw sum never falls below minus the largest valid bit count
	a_raw_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> raw_sum >= -18'sd65535)
		else $error("raw sum out of range");

endmodule

bind binary_xnor_popcount_conv_mac bxpc_checker u_bxpc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.last         (last),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.raw_sum      (raw_sum),
	.scaled_value (scaled_value)
);

// ===== verif/binary_xnor_popcount_conv_mac_tb.sv =====
// Self-checking testbench for the binary XNOR-popcount convolution MAC.
// Depends on bxpc_pkg and binary_xnor_popcount_conv_mac; predicts each result in-bench.
module binary_xnor_popcount_conv_mac_tb;

	localparam int unsigned WORD_BITS = 32;
	localparam logic [bxpc_pkg::WordW-1:0] WORD_MASK = 32'hFFFF_FFFF >> (32 - WORD_BITS);
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned DRAIN_CYCLES = 20;

	// content styles for a run of word pairs
	typedef enum int {
		FILL_RANDOM,
		FILL_NEAR_MATCH,
		FILL_NEAR_MISS,
		FILL_MATCH
	} fill_t;

	typedef struct {
		logic [bxpc_pkg::WordW-1:0]  act;
		logic [bxpc_pkg::WordW-1:0]  wgt;
		logic                        last;
		logic [bxpc_pkg::SumW-1:0]   vb;
		logic [bxpc_pkg::ScaleW-1:0] cs;
		logic [bxpc_pkg::ScaleW-1:0] ps;
	} word_pair_t;

	typedef struct {
		logic signed [bxpc_pkg::RawW-1:0]    raw;
		logic signed [bxpc_pkg::ScaledW-1:0] scaled;
	} conv_out_t;

	logic                                clk;
	logic                                arst_n;
	logic                                in_valid;
	logic                                in_stall;
	logic [bxpc_pkg::WordW-1:0]          act_word;
	logic [bxpc_pkg::WordW-1:0]          weight_word;
	logic                                last;
	logic [bxpc_pkg::SumW-1:0]           valid_bits;
	logic [bxpc_pkg::ScaleW-1:0]         channel_scale;
	logic [bxpc_pkg::ScaleW-1:0]         position_scale;
	logic                                out_valid;
	logic                                out_stall;
	logic signed [bxpc_pkg::RawW-1:0]    raw_sum;
	logic signed [bxpc_pkg::ScaledW-1:0] scaled_value;

	word_pair_t word_pair_q[$];
	conv_out_t  conv_out_q[$];
	word_pair_t next_pair;
	conv_out_t  want;

	logic [bxpc_pkg::TotalW-1:0] match_total;
	logic              in_taken;
	logic              hold_done;
	int unsigned       hold_left;
	int unsigned       n_taken;
	int unsigned       n_short;
	int unsigned       n_results;
	int unsigned       n_held;
	int unsigned       n_cycles;
	int unsigned       n_errors;
	int unsigned       n_rand;

	binary_xnor_popcount_conv_mac #(
		.WORD_BITS(WORD_BITS)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.act_word      (act_word),
		.weight_word   (weight_word),
		.last          (last),
		.valid_bits    (valid_bits),
		.channel_scale (channel_scale),
		.position_scale(position_scale),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.raw_sum       (raw_sum),
		.scaled_value  (scaled_value)
	);

	// free-running clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// idle phases: sender light / receiver heavy, then swapped, then none
	function automatic int unsigned idle_phase();
		int unsigned ph;
		ph = (n_short == 0) ? 0 : (n_taken * 3) / n_short;
		return (ph > 2) ? 2 : ph;
	endfunction

	function automatic int unsigned send_idle_pct();
		case (idle_phase())
			0: return 13;
			1: return 77;
			default: return 0;
		endcase
	endfunction

	function automatic int unsigned recv_stall_pct();
		case (idle_phase())
			0: return 77;
			1: return 13;
			default: return 0;
		endcase
	endfunction

	function automatic logic [bxpc_pkg::ScaleW-1:0] pick_scale();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return '1;
			2: return 16'h1000;
			default: return bxpc_pkg::ScaleW'($urandom);
		endcase
	endfunction

	task automatic add_pair(input logic [bxpc_pkg::WordW-1:0] a,
			input logic [bxpc_pkg::WordW-1:0] w, input logic l,
			input logic [bxpc_pkg::SumW-1:0] vb, input logic [bxpc_pkg::ScaleW-1:0] cs,
			input logic [bxpc_pkg::ScaleW-1:0] ps);
		word_pair_t p;
		p.act  = a;
		p.wgt  = w;
		p.last = l;
		p.vb   = vb;
		p.cs   = cs;
		p.ps   = ps;
		word_pair_q.push_back(p);
	endtask

	// queue one output position; leave it open when close is low
	task automatic add_packet(input int len, input fill_t style, input logic close);
		logic [bxpc_pkg::WordW-1:0] a;
		logic [bxpc_pkg::WordW-1:0] w;
		logic [bxpc_pkg::WordW-1:0] flip;
		logic [bxpc_pkg::SumW-1:0]  vb;
		logic             tail;
		int               nbits;
		for (int i = 0; i < len; i++) begin
			a = $urandom;
			flip = ($urandom_range(0, 3) == 0) ? (32'h1 << $urandom_range(0, 31)) : '0;
			case (style)
				FILL_RANDOM:     w = $urandom;
				FILL_NEAR_MATCH: w = a ^ flip;
				FILL_NEAR_MISS:  w = ~a ^ flip;
				default:         w = a;
			endcase
			tail = close && (i == len - 1);
			if (tail) begin
				nbits = len * 32;
				case ($urandom_range(0, 3))
					0: vb = bxpc_pkg::SumW'($urandom);
					1: vb = $urandom_range(0, 1) ? '1 : '0;
					default: vb = (nbits > 65535) ? '1 : bxpc_pkg::SumW'(nbits);
				endcase
			end else begin
				vb = bxpc_pkg::SumW'($urandom);
			end
			add_pair(a, w, tail, vb, tail ? pick_scale() : bxpc_pkg::ScaleW'($urandom),
				tail ? pick_scale() : bxpc_pkg::ScaleW'($urandom));
		end
	endtask

	// fold one accepted word pair into the match total; queue a result on last
	task automatic fold_pair();
		longint    tot;
		longint    raw;
		longint    prod;
		longint    vb_l;
		longint    cs_l;
		longint    ps_l;
		logic [bxpc_pkg::WordW-1:0] agree;
		conv_out_t r;
		agree = ~(act_word ^ weight_word) & WORD_MASK;
		tot = match_total;
		tot = tot + $countones(agree);
		if (tot > longint'(bxpc_pkg::TotalMax))
			tot = longint'(bxpc_pkg::TotalMax);
		match_total = bxpc_pkg::TotalW'(tot);
		if (!last)
			return;
		vb_l = valid_bits;
		cs_l = channel_scale;
		ps_l = position_scale;
		raw = 2 * tot - vb_l;
		if (raw > longint'(bxpc_pkg::RawMax))
			raw = longint'(bxpc_pkg::RawMax);
		prod = raw * cs_l * ps_l;
		if (prod > longint'(bxpc_pkg::ScaledMax))
			prod = longint'(bxpc_pkg::ScaledMax);
		if (prod < longint'(bxpc_pkg::ScaledMin))
			prod = longint'(bxpc_pkg::ScaledMin);
		r.raw = bxpc_pkg::RawW'(raw);
		r.scaled = bxpc_pkg::ScaledW'(prod);
		conv_out_q.push_back(r);
		match_total = '0;
	endtask

	// drive the input channel; hold the payload until it is taken
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (word_pair_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
				next_pair = word_pair_q.pop_front();
				act_word       <= next_pair.act;
				weight_word    <= next_pair.wgt;
				last           <= next_pair.last;
				valid_bits     <= next_pair.vb;
				channel_scale  <= next_pair.cs;
				position_scale <= next_pair.ps;
				in_valid       <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// drive the output stall; hold off once for a long stretch
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!hold_done && n_short != 0 && n_taken >= (n_short * 5) / 6) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct());
		end
	end

	// check results against the oldest prediction, then fold accepted inputs
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				n_results <= n_results + 1;
				if (conv_out_q.size() == 0) begin
					$display("%0t: result with nothing pending, raw_sum %0d scaled_value %0d",
						$time, raw_sum, scaled_value);
					n_errors++;
				end else begin
					want = conv_out_q.pop_front();
					if (raw_sum !== want.raw) begin
						$display("%0t: raw_sum mismatch, expected %0d, got %0d",
							$time, want.raw, raw_sum);
						n_errors++;
					end
					if (scaled_value !== want.scaled) begin
						$display("%0t: scaled_value mismatch, expected %0d, got %0d",
							$time, want.scaled, scaled_value);
						n_errors++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				fold_pair();
				n_taken <= n_taken + 1;
			end
			if (in_valid && in_stall)
				n_held <= n_held + 1;
		end
		in_taken <= arst_n && in_valid && !in_stall;
	end

	// abort a hung run
	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, n_cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		act_word       = '0;
		weight_word    = '0;
		last           = 1'b0;
		valid_bits     = '0;
		channel_scale  = '0;
		position_scale = '0;
		out_stall      = 1'b0;
		in_taken       = 1'b0;
		hold_done      = 1'b0;
		hold_left      = 0;
		match_total    = '0;
		n_taken        = 0;
		n_short        = 0;
		n_results      = 0;
		n_held         = 0;
		n_cycles       = 0;
		n_errors       = 0;
		n_rand         = 0;

		// directed: unit scales, lowest raw sum, zero scales, ignored fields on non-last
		add_pair(32'h0000_0000, 32'h0000_0000, 1'b1, 16'd32, 16'h1000, 16'h1000);
		add_pair(32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		add_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'h0000, 16'h0000, 16'hFFFF);
		add_pair(32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		add_pair(32'h5555_5555, 32'h5555_5555, 1'b0, 16'h0000, 16'h0000, 16'h0000);
		add_pair(32'h1234_5678, 32'h1234_5678, 1'b1, 16'd16, 16'hFFFF, 16'h0000);
		add_pair(32'h0F0F_0F0F, 32'h0F0F_00FF, 1'b1, 16'hFFFF, 16'h0001, 16'h0001);
		add_pair(32'hFFFF_0000, 32'h0000_FFFF, 1'b1, 16'h0000, 16'hFFFF, 16'h0001);
		add_pair(32'hDEAD_BEEF, 32'hDEAD_BEEF, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		add_pair(32'hCAFE_F00D, 32'h3501_0FF2, 1'b0, 16'h8000, 16'h8000, 16'h8000);
		add_pair(32'h8000_0001, 32'h8000_0001, 1'b1, 16'd48, 16'h8000, 16'h8000);
		add_pair(32'h7FFF_FFFF, 32'hFFFF_FFFE, 1'b1, 16'd1, 16'hFFFF, 16'hFFFF);

		// random positions: mostly short, some long
		while (n_rand < 700) begin
			int   len;
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
			add_packet(len, fill_t'($urandom_range(0, 3)), 1'b1);
			n_rand += len;
		end
		n_short = word_pair_q.size();

		// build a large match total, then push the scaled value past its top
		add_packet(600, FILL_MATCH, 1'b0);
		add_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'h0000, 16'hFFFF, 16'hFFFF);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// wait for every pair to be taken and every result to drain
		while (word_pair_q.size() != 0 || in_valid)
			@(posedge clk);
		while (conv_out_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("checked %0d results from %0d word pairs in %0d cycles", n_results, n_taken,
			n_cycles);
		$display("input held off by the block for %0d cycles, long output hold included",
			n_held);
		if (n_errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
